// ===== src/pkfrl_pkg.sv =====
// ----------------------------------------------------------------------------
// pkfrl_pkg
// Shared types and constants for the per-key failure rate limiter.
// ----------------------------------------------------------------------------
package pkfrl_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TIME_W-1:0]  WINDOW_RESET  = TIME_W'(300);
  localparam logic [COUNT_W-1:0] MAXFAIL_RESET = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW   = 1'b0,
    REG_MAX_FAIL = 1'b1
  } cfg_reg_e;

  localparam logic KIND_CHECK  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  uid;
    logic              ok;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic               blocked;
    logic               found;
    logic [COUNT_W-1:0] failures_after;
    logic               evicted;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] failures;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic decide;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last_addr;
  } dp_status_t;

endpackage

// ===== src/pkfrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pkfrl_ctrl
// Sequencer: accepts a transaction, walks the table scan, then commits.
// ----------------------------------------------------------------------------
module pkfrl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pkfrl_pkg::dp_status_t status,
  output pkfrl_pkg::ctrl_cmd_t  cmd,
  output logic                  busy,
  output logic                  done
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_LAST   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = status.empty ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_addr) begin
          state_next = S_LAST;
        end
      end
      // last read data is compared in this cycle
      S_LAST: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DECIDE);
    end
  end

  assign busy = (state != S_IDLE);

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

// ===== src/pkfrl_dp.sv =====
// ----------------------------------------------------------------------------
// pkfrl_dp
// Datapath: entry memory, fill count, scan trackers, update and result.
// ----------------------------------------------------------------------------
module pkfrl_dp #(
  parameter int TABLE_ENTRIES = pkfrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pkfrl_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pkfrl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  pkfrl_pkg::item_t                    item,
  input  pkfrl_pkg::ctrl_cmd_t                cmd,
  output pkfrl_pkg::dp_status_t               status,
  output pkfrl_pkg::result_t                  result
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // configuration registers
  logic [pkfrl_pkg::TIME_W-1:0]  window_seconds;
  logic [pkfrl_pkg::COUNT_W-1:0] max_failures;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= pkfrl_pkg::WINDOW_RESET;
      max_failures   <= pkfrl_pkg::MAXFAIL_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        pkfrl_pkg::REG_WINDOW:   window_seconds <= cfg_data[pkfrl_pkg::TIME_W-1:0];
        pkfrl_pkg::REG_MAX_FAIL: max_failures   <= cfg_data[pkfrl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // entries fill from index 0 and are never freed, so valid == below fill
  logic [CNT_W-1:0] fill;
  logic             has_free;

  assign has_free = (fill != CNT_W'(TABLE_ENTRIES));

  pkfrl_pkg::item_t cur;
  logic [IDX_W-1:0] addr;

  pkfrl_pkg::entry_t mem [TABLE_ENTRIES];
  pkfrl_pkg::entry_t rd_entry;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vld;

  // scan trackers
  logic                          hit_vld;
  logic [IDX_W-1:0]              hit_idx;
  logic [pkfrl_pkg::COUNT_W-1:0] hit_fail;
  logic [pkfrl_pkg::TIME_W-1:0]  hit_age;
  logic                          old_vld;
  logic [IDX_W-1:0]              old_idx;
  logic [pkfrl_pkg::TIME_W-1:0]  old_age;

  logic [pkfrl_pkg::TIME_W-1:0]  rd_age;
  logic                          rd_match;

  assign rd_age   = cur.now - rd_entry.stamp;
  assign rd_match = (rd_entry.key == cur.uid);

  assign status.empty     = (fill == '0);
  assign status.last_addr = ((CNT_W'(addr) + CNT_W'(1)) == fill);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.load) begin
        addr <= '0;
      end else if (cmd.issue) begin
        addr <= addr + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_vld <= 1'b0;
      old_vld <= 1'b0;
    end else if (cmd.load) begin
      hit_vld <= 1'b0;
      old_vld <= 1'b0;
    end else if (rd_vld) begin
      if (rd_match && !hit_vld) begin
        hit_vld <= 1'b1;
      end
      // strict greater keeps the lowest index on equal age
      if (!old_vld || (rd_age > old_age)) begin
        old_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && rd_match && !hit_vld) begin
      hit_idx  <= rd_idx;
      hit_fail <= rd_entry.failures;
      hit_age  <= rd_age;
    end
    if (rd_vld && (!old_vld || (rd_age > old_age))) begin
      old_idx <= rd_idx;
      old_age <= rd_age;
    end
  end

  // update of the matched or new entry
  logic [pkfrl_pkg::COUNT_W-1:0] upd_count;
  logic                          in_window;
  pkfrl_pkg::entry_t             wr_entry;
  logic [IDX_W-1:0]              wr_idx;
  logic                          wr_en;
  pkfrl_pkg::result_t            res_next;

  assign in_window = (hit_age <= window_seconds);

  always_comb begin
    upd_count = in_window ? hit_fail : '0;
    if (cur.ok) begin
      upd_count = '0;
    end else if (upd_count != pkfrl_pkg::COUNT_MAX) begin
      upd_count = upd_count + pkfrl_pkg::COUNT_W'(1);
    end

    res_next = '0;
    wr_en    = 1'b0;
    wr_idx   = hit_idx;
    wr_entry.key      = cur.uid;
    wr_entry.stamp    = cur.now;
    wr_entry.failures = upd_count;

    if (cur.kind == pkfrl_pkg::KIND_CHECK) begin
      if (hit_vld) begin
        res_next.found          = 1'b1;
        res_next.failures_after = hit_fail;
        res_next.blocked        = in_window && (hit_fail >= max_failures);
      end
    end else if (hit_vld) begin
      res_next.found          = 1'b1;
      res_next.failures_after = upd_count;
      wr_en                   = cmd.decide;
    end else begin
      wr_entry.failures       = cur.ok ? '0 : pkfrl_pkg::COUNT_W'(1);
      res_next.failures_after = wr_entry.failures;
      res_next.evicted        = !has_free;
      wr_idx                  = has_free ? fill[IDX_W-1:0] : old_idx;
      wr_en                   = cmd.decide;
    end
  end

  // single read port for the scan, one write at commit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (cmd.issue) begin
      rd_entry <= mem[addr];
      rd_idx   <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.decide && (cur.kind == pkfrl_pkg::KIND_RECORD) && !hit_vld
                 && has_free) begin
      fill <= fill + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      result <= res_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (CNT_W'(rd_idx) < fill))
    else $error("scan read beyond filled entries");

endmodule

// ===== src/per_key_failure_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// per_key_failure_rate_limiter
// Per-key failed attempt limiter with a table of keys and oldest-entry
// eviction; one result per transaction.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   input     start, busy            item   (kind, uid, ok, now)
//   result    done (1-cycle strobe)  result (blocked, found, failures_after,
//                                            evicted)
//   config    cfg_we                 cfg_idx, cfg_data
//
// Each transaction scans the filled entries through the memory's single read
// port, one entry a cycle, then commits; an empty table skips the scan.
// A new transaction is taken in the cycle that done is high.
// Reset empties the table at once (fill count) and loads register defaults.
// The receiver cannot stall; a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module per_key_failure_rate_limiter #(
  parameter int TABLE_ENTRIES = pkfrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  pkfrl_pkg::item_t                 item,
  output logic                             done,
  output pkfrl_pkg::result_t               result,
  input  logic                             cfg_we,
  input  logic [pkfrl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pkfrl_pkg::CFG_DATA_W-1:0] cfg_data
);

  pkfrl_pkg::ctrl_cmd_t  cmd;
  pkfrl_pkg::dp_status_t status;

  pkfrl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pkfrl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-key failure rate limiter. A queue of
// directed and random transactions feeds the command port, a scoreboard
// keeps its own copy of the key table and compares every result strobe.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SLOTS       = pkfrl_pkg::TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT = 8 * (SLOTS + 3);

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  pkfrl_pkg::item_t                 item = '0;
  logic                             done;
  pkfrl_pkg::result_t               result;
  logic                             cfg_we = 1'b0;
  logic [pkfrl_pkg::CFG_IDX_W-1:0]  cfg_idx = pkfrl_pkg::REG_WINDOW;
  logic [pkfrl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // scoreboard copy of the limiter
  logic [pkfrl_pkg::TIME_W-1:0]  lim_window = pkfrl_pkg::WINDOW_RESET;
  logic [pkfrl_pkg::COUNT_W-1:0] lim_cap = pkfrl_pkg::MAXFAIL_RESET;
  logic                          slot_used [SLOTS];
  logic [pkfrl_pkg::KEY_W-1:0]   slot_key [SLOTS];
  logic [pkfrl_pkg::COUNT_W-1:0] slot_count [SLOTS];
  logic [pkfrl_pkg::TIME_W-1:0]  slot_stamp [SLOTS];

  pkfrl_pkg::item_t   attempt_q [$];
  pkfrl_pkg::result_t outcome_q [$];
  pkfrl_pkg::result_t want;
  int                 gap_pct = 38;
  int                 errors = 0;
  int                 stall_cycles = 0;

  per_key_failure_rate_limiter uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      slot_used[k] = 1'b0;
    end
  end

  // updates the table copy and returns the outcome of one transaction
  function automatic pkfrl_pkg::result_t predict_outcome(pkfrl_pkg::item_t it);
    pkfrl_pkg::result_t            r;
    int                            i;
    int                            hit;
    int                            free_i;
    int                            old_i;
    logic [pkfrl_pkg::TIME_W-1:0]  age;
    logic [pkfrl_pkg::TIME_W-1:0]  old_age;
    logic [pkfrl_pkg::COUNT_W-1:0] count;
    r = '0;
    hit = -1;
    free_i = -1;
    old_i = -1;
    old_age = '0;
    count = '0;
    for (i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == it.uid) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      count = slot_count[hit];
      age = it.now - slot_stamp[hit];
      if (it.kind == pkfrl_pkg::KIND_CHECK) begin
        r.blocked = (age <= lim_window) && (count >= lim_cap);
      end else begin
        // stale count is cleared first, then the outcome applies
        if (age > lim_window) count = '0;
        if (it.ok) count = '0;
        else if (count != pkfrl_pkg::COUNT_MAX) count = count + pkfrl_pkg::COUNT_W'(1);
        slot_count[hit] = count;
        slot_stamp[hit] = it.now;
      end
    end else if (it.kind == pkfrl_pkg::KIND_RECORD) begin
      for (i = 0; i < SLOTS; i++) begin
        if (!slot_used[i]) begin
          if (free_i < 0) free_i = i;
        end else begin
          age = it.now - slot_stamp[i];
          if (old_i < 0 || age > old_age) begin
            old_i = i;
            old_age = age;
          end
        end
      end
      if (free_i < 0) begin
        free_i = old_i;
        r.evicted = 1'b1;
      end
      count = it.ok ? pkfrl_pkg::COUNT_W'(0) : pkfrl_pkg::COUNT_W'(1);
      slot_used[free_i] = 1'b1;
      slot_key[free_i] = it.uid;
      slot_count[free_i] = count;
      slot_stamp[free_i] = it.now;
    end
    r.failures_after = count;
    return r;
  endfunction

  // driver: start stays up across back-to-back transactions
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) outcome_q.push_back(predict_outcome(item));
      if (attempt_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        start <= 1'b1;
        item  <= attempt_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with nothing pending, got %p", $time, result);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (result.blocked !== want.blocked) begin
          $display("%0t: blocked expected %0b actual %0b", $time, want.blocked,
                   result.blocked);
          errors++;
        end
        if (result.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, result.found);
          errors++;
        end
        if (result.failures_after !== want.failures_after) begin
          $display("%0t: failures_after expected %0d actual %0d", $time,
                   want.failures_after, result.failures_after);
          errors++;
        end
        if (result.evicted !== want.evicted) begin
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
                   result.evicted);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sampled at the falling edge so that queue and port state agree
  task automatic wait_idle();
    while (attempt_q.size() != 0 || start || outcome_q.size() != 0 || busy)
      @(negedge clk);
  endtask

  task automatic write_reg(pkfrl_pkg::cfg_reg_e idx,
                           logic [pkfrl_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == pkfrl_pkg::REG_WINDOW) lim_window = data;
    else lim_cap = data[pkfrl_pkg::COUNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_attempt(logic kind, logic [pkfrl_pkg::KEY_W-1:0] uid, logic ok,
                              logic [pkfrl_pkg::TIME_W-1:0] now);
    pkfrl_pkg::item_t it;
    it.kind = kind;
    it.uid  = uid;
    it.ok   = ok;
    it.now  = now;
    attempt_q.push_back(it);
  endtask

  // keys come from a pool so that lookups hit; stray keys are fully random
  task automatic run_phase(logic [pkfrl_pkg::TIME_W-1:0] win,
                           logic [pkfrl_pkg::CFG_DATA_W-1:0] cap_data,
                           int idle, int n, int pool_n, int check_pct, int fail_pct,
                           int stray_pct, int step_max, logic [pkfrl_pkg::TIME_W-1:0] t0);
    logic [pkfrl_pkg::KEY_W-1:0]  keys [$];
    logic [pkfrl_pkg::TIME_W-1:0] t;
    int                           j;
    wait_idle();
    write_reg(pkfrl_pkg::REG_WINDOW, win);
    write_reg(pkfrl_pkg::REG_MAX_FAIL, cap_data);
    gap_pct = idle;
    t = t0;
    for (j = 0; j < pool_n; j++) keys.push_back($urandom);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(99) < 2) t = $urandom;
      else t = t + $urandom_range(step_max);
      push_attempt(($urandom_range(99) < check_pct) ? pkfrl_pkg::KIND_CHECK
                                                    : pkfrl_pkg::KIND_RECORD,
                   ($urandom_range(99) < stray_pct) ? $urandom
                                                    : keys[$urandom_range(pool_n - 1)],
                   ($urandom_range(99) < fail_pct) ? 1'b0 : 1'b1, t);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // register defaults: window 300, limit 5
    push_attempt(pkfrl_pkg::KIND_CHECK, 32'h0000_0000, 1'b1, 32'd0);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 32'd100);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 32'd110);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 32'd120);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 32'd130);
    push_attempt(pkfrl_pkg::KIND_CHECK, 32'hFFFF_FFFF, 1'b0, 32'd130);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 32'd140);
    // age equal to the window still blocks, one more second does not
    push_attempt(pkfrl_pkg::KIND_CHECK, 32'hFFFF_FFFF, 1'b1, 32'd440);
    push_attempt(pkfrl_pkg::KIND_CHECK, 32'hFFFF_FFFF, 1'b0, 32'd441);
    // stale count cleared before the increment
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 32'd441);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'hFFFF_FFFF, 1'b1, 32'd450);
    // age taken across the time wrap
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'h0000_0000, 1'b1, 32'hFFFF_FFF0);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'h0000_0000, 1'b0, 32'h0000_0010);
    push_attempt(pkfrl_pkg::KIND_CHECK, 32'h0000_0000, 1'b1, 32'h0000_0010);
    push_attempt(pkfrl_pkg::KIND_RECORD, 32'h5555_AAAA, 1'b1, 32'hAAAA_5555);
    push_attempt(pkfrl_pkg::KIND_CHECK, 32'hAAAA_5555, 1'b0, 32'h5555_AAAA);

    run_phase(32'd300, 32'd3, 38, 120, 12, 40, 70, 10, 30, 32'hFFFF_F800);
    // zero window with more keys than slots: eviction and age ties
    run_phase(32'd0, 32'd1, 38, 150, 160, 30, 60, 10, 3, $urandom);
    // one key hammered with failures until the count saturates
    run_phase(32'hFFFF_FFFF, 32'd255, 48, 320, 1, 10, 100, 0, 1000, $urandom);
    // limit register masked down to zero
    run_phase($urandom_range(5000, 50), 32'hFFFF_FF00, 48, 120, 40, 50, 70, 5, 400,
              $urandom);
    run_phase($urandom_range(600, 100), $urandom_range(8, 1), 0, 160, 200, 30, 50, 10,
              20, 32'hFFFF_FFC0);

    wait_idle();
    repeat (SLOTS + 3) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
